FILE: rtl/ccsb_pkg.sv
// ----------------------------------------------------------------------------
// ccsb_pkg
// Shared types and constants for the column completion scoreboard.
// ----------------------------------------------------------------------------
package ccsb_pkg;

    localparam int DEF_MAX_COLUMNS    = 16;
    localparam int DEF_MAX_ROW_GROUPS = 64;

    localparam int COL_W      = 4;   // column field
    localparam int ROW_IDX_W  = 6;   // row-group index fields
    localparam int CCOUNT_W   = 5;   // column_count register
    localparam int RCOUNT_W   = 7;   // row_group_count register
    localparam int CFG_DATA_W = 7;   // widest register
    localparam int CNT_W      = 7;   // counts up to 64

    typedef enum logic [0:0] {
        REG_COLUMN_COUNT    = 1'b0,
        REG_ROW_GROUP_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        OP_MARK = 1'b0,
        OP_POP  = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t                opcode;
        logic [COL_W-1:0]       column;
        logic [ROW_IDX_W-1:0]   range_first;
        logic [ROW_IDX_W-1:0]   range_last;
    } cmd_t;

    typedef struct packed {
        logic                   found;
        logic [ROW_IDX_W-1:0]   row_group;
    } result_t;

    typedef struct packed {
        logic merge;
        logic pop;
    } ready_ctl_t;

endpackage

FILE: rtl/ccsb_done_mem.sv
// ----------------------------------------------------------------------------
// ccsb_done_mem
// Done-bit memory, one word per column, registered read.
// Per-entry valid flags make unwritten words read as zero after reset.
// ----------------------------------------------------------------------------
module ccsb_done_mem
    import ccsb_pkg::*;
#(
    parameter int MAX_COLUMNS    = DEF_MAX_COLUMNS,
    parameter int MAX_ROW_GROUPS = DEF_MAX_ROW_GROUPS,
    localparam int COL_AW        = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [COL_AW-1:0]         wr_addr,
    input  logic [MAX_ROW_GROUPS-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [COL_AW-1:0]         rd_addr,
    output logic [MAX_ROW_GROUPS-1:0] rd_data
);

    logic [MAX_ROW_GROUPS-1:0] mem [MAX_COLUMNS];
    logic [MAX_COLUMNS-1:0]    valid_reg;
    logic [MAX_ROW_GROUPS-1:0] data_reg;
    logic                      data_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            data_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                data_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // never-written words read as zero
    assign rd_data = data_valid_reg ? data_reg : '0;

endmodule

FILE: rtl/ccsb_ready_set.sv
// ----------------------------------------------------------------------------
// ccsb_ready_set
// Set of ready row groups: merges new groups in, pops the lowest one.
// A pop registers the isolated lowest bit, which is then encoded combinationally.
// ----------------------------------------------------------------------------
module ccsb_ready_set
    import ccsb_pkg::*;
#(
    parameter int MAX_ROW_GROUPS = DEF_MAX_ROW_GROUPS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ready_ctl_t                ctl,
    input  logic [MAX_ROW_GROUPS-1:0] merge_bits,
    output logic                      result_strobe,
    output result_t                   result
);

    logic [MAX_ROW_GROUPS-1:0] ready_reg;
    logic [MAX_ROW_GROUPS-1:0] lowbit_reg;
    logic                      pend_reg;
    logic [ROW_IDX_W-1:0]      index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            pend_reg <= ctl.pop;
            if (ctl.merge)
            begin
                ready_reg <= ready_reg | merge_bits;
            end
            else if (pend_reg)
            begin
                // drop the popped group
                ready_reg <= ready_reg & ~lowbit_reg;
            end
        end
    end

    // isolate lowest set bit
    always_ff @(posedge clk)
    begin
        if (ctl.pop)
        begin
            lowbit_reg <= ready_reg & (~ready_reg + MAX_ROW_GROUPS'(1));
        end
    end

    always_comb
    begin
        index = '0;
        for (int i = 0; i < MAX_ROW_GROUPS; i++)
        begin
            if (lowbit_reg[i])
            begin
                index = index | ROW_IDX_W'(i);
            end
        end
    end

    assign result_strobe    = pend_reg;
    assign result.found     = |lowbit_reg;
    assign result.row_group = index;

endmodule

FILE: rtl/column_completion_scoreboard_top.sv
// ----------------------------------------------------------------------------
// column_completion_scoreboard_top
// Completion scoreboard: done bits per column and row group, ready set pop.
// ----------------------------------------------------------------------------
// Pop: result strobe in the cycle after the request, while the block is busy.
// Mark: busy through the read-modify-write of the column word and the scan of
//   one done word per cycle through the single memory read port; an ignored
//   mark does not make the block busy.
// No result for a mark. Results cannot be stalled.
// Reset: ready set and done-bit valid flags clear at once; no sweep.
// ----------------------------------------------------------------------------
module column_completion_scoreboard_top
    import ccsb_pkg::*;
#(
    parameter int MAX_COLUMNS    = DEF_MAX_COLUMNS,
    parameter int MAX_ROW_GROUPS = DEF_MAX_ROW_GROUPS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  cmd_t                  cmd,
    output logic                  result_strobe,
    output result_t               result,
    input  logic                  cfg_we,
    input  cfg_reg_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam logic [CNT_W-1:0] MAX_COLS_C = CNT_W'(MAX_COLUMNS);
    localparam logic [CNT_W-1:0] MAX_ROWS_C = CNT_W'(MAX_ROW_GROUPS);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MARK  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_POP   = 5'b10000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CCOUNT_W-1:0]       col_count_reg;
    logic [RCOUNT_W-1:0]       row_count_reg;
    logic [COL_AW-1:0]         col_reg;
    logic [MAX_ROW_GROUPS-1:0] mask_reg, mask_next;
    logic [MAX_ROW_GROUPS-1:0] acc_reg;
    logic [CNT_W-1:0]          scan_reg;
    logic                      pend_reg;

    logic [CNT_W-1:0]          ncols;
    logic [CNT_W-1:0]          nrows;
    logic                      accept;
    logic                      mark_ok;
    logic                      mem_wr_en;
    logic                      mem_rd_en;
    logic [COL_AW-1:0]         mem_rd_addr;
    logic [MAX_ROW_GROUPS-1:0] mem_rd_data;
    ready_ctl_t                ready_ctl;

    assign ncols = ({2'b0, col_count_reg} > MAX_COLS_C) ? MAX_COLS_C
                                                       : {2'b0, col_count_reg};
    assign nrows = (row_count_reg > MAX_ROWS_C) ? MAX_ROWS_C : row_count_reg;

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign mark_ok = ({3'b0, cmd.column} < ncols) && (cmd.range_last >= cmd.range_first);

    always_comb
    begin
        mask_next = '0;
        for (int i = 0; i < MAX_ROW_GROUPS; i++)
        begin
            mask_next[i] = (CNT_W'(i) >= {1'b0, cmd.range_first})
                        && (CNT_W'(i) <= {1'b0, cmd.range_last})
                        && (CNT_W'(i) < nrows);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= CCOUNT_W'(16);
            row_count_reg <= RCOUNT_W'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COLUMN_COUNT:    col_count_reg <= cfg_data[CCOUNT_W-1:0];
                REG_ROW_GROUP_COUNT: row_count_reg <= cfg_data[RCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.opcode == OP_POP)
                    begin
                        state_next = ST_POP;
                    end
                    else if (mark_ok)
                    begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK:  state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_reg == ncols - CNT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_IDLE;
            ST_POP:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            scan_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == ST_SCAN);
            if (state_reg == ST_MARK)
            begin
                scan_reg <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                scan_reg <= scan_reg + CNT_W'(1);
            end
        end
    end

    // hold the request payload and fold done words into the accumulator
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg  <= COL_AW'({3'b0, cmd.column});
            mask_reg <= mask_next;
        end
        if (state_reg == ST_MARK)
        begin
            acc_reg <= mask_reg;
        end
        else if (pend_reg)
        begin
            acc_reg <= acc_reg & mem_rd_data;
        end
    end

    assign mem_wr_en   = (state_reg == ST_MARK);
    assign mem_rd_en   = (accept && (cmd.opcode == OP_MARK)) || (state_reg == ST_SCAN);
    assign mem_rd_addr = (state_reg == ST_SCAN) ? scan_reg[COL_AW-1:0]
                                                : COL_AW'({3'b0, cmd.column});

    ccsb_done_mem #(
        .MAX_COLUMNS    (MAX_COLUMNS),
        .MAX_ROW_GROUPS (MAX_ROW_GROUPS)
    ) u_done_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (col_reg),
        .wr_data (mem_rd_data | mask_reg),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign ready_ctl.merge = (state_reg == ST_DRAIN);
    assign ready_ctl.pop   = accept && (cmd.opcode == OP_POP);

    ccsb_ready_set #(
        .MAX_ROW_GROUPS (MAX_ROW_GROUPS)
    ) u_ready_set (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ready_ctl),
        .merge_bits    (acc_reg & mem_rd_data),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

FILE: rtl/ccsb_checker.sv
// ----------------------------------------------------------------------------
// ccsb_assertions
// Port-level checks for the column completion scoreboard, bound to the top.
// ----------------------------------------------------------------------------
module ccsb_assertions
    import ccsb_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input cmd_t    cmd,
    input logic    result_strobe,
    input result_t result
);

    // a pop request answers in the next cycle
    a_pop_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.opcode == OP_POP)) |=> result_strobe)
        else $error("pop request without result");

    // every result traces back to a pop request in the previous cycle
    a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(start && !busy && (cmd.opcode == OP_POP)))
        else $error("result without pop request");

    // not-found result carries row group zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.found) |-> (result.row_group == '0))
        else $error("not-found result with nonzero row group");

    // the block is busy while a pop result is out
    a_busy_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> busy)
        else $error("result strobe while idle");

endmodule

bind column_completion_scoreboard_top ccsb_assertions u_ccsb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .result_strobe (result_strobe),
    .result        (result)
);

FILE: test/ccsb_checker.sv
// ----------------------------------------------------------------------------
// ccsb_checker
// Watches the request, result and register ports of the completion
// scoreboard, keeps its own copy of the done bits and the ready set, and
// compares every pop result with the predicted one.
// ----------------------------------------------------------------------------
module ccsb_checker
    import ccsb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  cmd_t                  cmd,
    input  logic                  result_strobe,
    input  result_t               result,
    input  logic                  cfg_we,
    input  cfg_reg_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    logic [DEF_MAX_ROW_GROUPS-1:0] done_words [DEF_MAX_COLUMNS];
    logic [DEF_MAX_ROW_GROUPS-1:0] ready_groups;
    logic [CCOUNT_W-1:0]           column_count;
    logic [RCOUNT_W-1:0]           row_group_count;
    result_t                       expected_pops [$];

    // Update the shadow state for one request; a pop queues its result.
    task automatic apply_request(input cmd_t c);
        int                            ncols;
        int                            nrows;
        int                            i;
        int                            lowest;
        logic [DEF_MAX_ROW_GROUPS-1:0] span;
        logic [DEF_MAX_ROW_GROUPS-1:0] common;
        result_t                       r;
        ncols = (column_count > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : int'(column_count);
        nrows = (row_group_count > DEF_MAX_ROW_GROUPS) ? DEF_MAX_ROW_GROUPS
                                                       : int'(row_group_count);
        if (c.opcode == OP_MARK) begin
            // inactive column or empty range: no effect
            if (int'(c.column) < ncols && c.range_last >= c.range_first) begin
                for (i = 0; i < DEF_MAX_ROW_GROUPS; i++)
                    span[i] = (i >= c.range_first) && (i <= c.range_last) && (i < nrows);
                done_words[c.column] = done_words[c.column] | span;
                common = span;
                for (i = 0; i < ncols; i++)
                    common = common & done_words[i];
                ready_groups = ready_groups | common;
            end
        end
        else begin
            r.found = 1'b0;
            r.row_group = '0;
            if (ready_groups != '0) begin
                lowest = 0;
                while (!ready_groups[lowest])
                    lowest++;
                ready_groups[lowest] = 1'b0;
                r.found = 1'b1;
                r.row_group = lowest[ROW_IDX_W-1:0];
            end
            expected_pops.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        int      e;
        if (!rst_n) begin
            for (e = 0; e < DEF_MAX_COLUMNS; e++)
                done_words[e] = '0;
            ready_groups = '0;
            column_count = CCOUNT_W'(DEF_MAX_COLUMNS);
            row_group_count = RCOUNT_W'(DEF_MAX_ROW_GROUPS);
            expected_pops.delete();
            errors <= 0;
            pending <= 0;
        end
        else begin
            e = errors;
            if (result_strobe) begin
                if (expected_pops.size() == 0) begin
                    if (e < REPORT_LIMIT)
                        $display("unexpected result: found=%0d row_group=%0d",
                                 result.found, result.row_group);
                    e++;
                end
                else begin
                    want = expected_pops.pop_front();
                    if (result.found !== want.found || result.row_group !== want.row_group) begin
                        if (e < REPORT_LIMIT)
                            $display("pop mismatch: expected found=%0d row_group=%0d, got found=%0d row_group=%0d",
                                     want.found, want.row_group, result.found, result.row_group);
                        e++;
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_COLUMN_COUNT:    column_count = cfg_data[CCOUNT_W-1:0];
                    REG_ROW_GROUP_COUNT: row_group_count = cfg_data[RCOUNT_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                apply_request(cmd);
            errors <= e;
            pending <= expected_pops.size();
        end
    end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the completion scoreboard through a directed opening and a series
// of register settings, each with completion rounds over all active columns,
// pops and random requests; the checker module judges every pop result.
// ----------------------------------------------------------------------------
module testbench;
    import ccsb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TARGET_REQUESTS = 1400;
    localparam int PHASE_REQUESTS  = 70;
    localparam int DRAIN_CYCLES    = 2 * DEF_MAX_COLUMNS + 8;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int FIXED_SETTINGS  = 7;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    cmd_t                  cmd;
    logic                  result_strobe;
    result_t               result;
    logic                  cfg_we;
    cfg_reg_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    cycles;
    int                    requests_sent;
    int                    active_cols;
    int                    tracked_rows;
    bit                    steady;

    // column count, row-group count: extremes first
    int fixed_cols [FIXED_SETTINGS] = '{16, 1, 0, 31, 16, 2, 5};
    int fixed_rows [FIXED_SETTINGS] = '{64, 1, 64, 127, 0, 64, 33};

    column_completion_scoreboard_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .result_strobe (result_strobe),
        .result        (result),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    ccsb_checker scoreboard_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .result_strobe (result_strobe),
        .result        (result),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic issue(input opcode_t op, input int col, input int first, input int last);
        cmd_t c;
        c.opcode = op;
        c.column = col[COL_W-1:0];
        c.range_first = first[ROW_IDX_W-1:0];
        c.range_last = last[ROW_IDX_W-1:0];
        if (!steady && $urandom_range(0, 99) < 21) begin
            @(negedge clk) start <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic pop_random();
        issue(OP_POP, $urandom_range(0, 15), $urandom_range(0, 63), $urandom_range(0, 63));
    endtask

    // Hold until every pop has returned and the block is idle.
    task automatic settle();
        @(negedge clk) start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk) cfg_we <= 1'b0;
    endtask

    task automatic configure(input int cols, input int rows);
        logic [CFG_DATA_W-1:0] value;
        // upper data bits are outside the column count register
        value = {2'($urandom_range(0, 3)), cols[CCOUNT_W-1:0]};
        write_reg(REG_COLUMN_COUNT, value);
        write_reg(REG_ROW_GROUP_COUNT, rows[RCOUNT_W-1:0]);
        active_cols = (cols % 32 > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : cols % 32;
        tracked_rows = (rows > DEF_MAX_ROW_GROUPS) ? DEF_MAX_ROW_GROUPS : rows;
    endtask

    // Mark one range in every active column, now and then skipping a column
    // or splitting its range in two, then pop a few times.
    task automatic completion_round();
        int first;
        int last;
        int lo;
        int hi;
        int mid;
        int k;
        first = $urandom_range(0, (tracked_rows > 0 ? tracked_rows : 64) - 1);
        if ($urandom_range(0, 9) == 0)
            first = $urandom_range(0, 63);
        last = first + $urandom_range(0, 7);
        if (last > 63)
            last = 63;
        for (k = 0; k < active_cols; k++) begin
            lo = first - $urandom_range(0, 2);
            hi = last + $urandom_range(0, 2);
            if (lo < 0)
                lo = 0;
            if (hi > 63)
                hi = 63;
            if ($urandom_range(0, 9) == 0)
                continue;
            if ($urandom_range(0, 3) == 0 && hi > lo) begin
                mid = $urandom_range(lo, hi - 1);
                issue(OP_MARK, k, lo, mid);
                issue(OP_MARK, k, mid + 1, hi);
            end
            else
                issue(OP_MARK, k, lo, hi);
        end
        repeat ($urandom_range(1, 4)) pop_random();
    endtask

    initial
    begin
        int k;
        int phase;
        int phase_end;
        int cols;
        int rows;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_index = REG_COLUMN_COUNT;
        cfg_data = '0;
        cycles = 0;
        requests_sent = 0;
        active_cols = DEF_MAX_COLUMNS;
        tracked_rows = DEF_MAX_ROW_GROUPS;
        steady = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Directed opening with reset register values.
        issue(OP_POP, 15, 63, 0);
        for (k = 0; k < DEF_MAX_COLUMNS; k++)
            issue(OP_MARK, k, 0, 63);
        issue(OP_POP, 0, 0, 0);
        issue(OP_MARK, 9, 0, 0);     // re-mark returns a popped group
        issue(OP_POP, 7, 12, 40);
        issue(OP_MARK, 2, 40, 39);   // empty range
        issue(OP_POP, 0, 0, 0);
        issue(OP_MARK, 0, 63, 63);
        issue(OP_POP, 15, 63, 63);

        phase = 0;
        while (requests_sent < TARGET_REQUESTS) begin
            settle();
            if (phase < FIXED_SETTINGS) begin
                cols = fixed_cols[phase];
                rows = fixed_rows[phase];
            end
            else begin
                k = $urandom_range(0, 9);
                cols = (k < 7) ? $urandom_range(1, 4) :
                       (k < 9) ? $urandom_range(5, 16) : $urandom_range(0, 31);
                k = $urandom_range(0, 19);
                rows = (k < 12) ? $urandom_range(1, 64) :
                       (k < 15) ? 64 : $urandom_range(0, 127);
            end
            configure(cols, rows);
            steady = (phase == 3) || (phase == 11);
            phase_end = requests_sent + PHASE_REQUESTS;
            while (requests_sent < phase_end) begin
                k = $urandom_range(0, 99);
                if (k < 65)
                    completion_round();
                else if (k < 75)
                    pop_random();
                else
                    issue(opcode_t'($urandom_range(0, 1)), $urandom_range(0, 15),
                          $urandom_range(0, 63), $urandom_range(0, 63));
            end
            phase++;
        end

        settle();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
